>>> design/bea_pkg.sv
// shared types and constants for the button edge and auto-repeat block
package bea_pkg;

	localparam int LINE_W = 8;
	localparam int TIMER_W = 8;
	localparam int CFG_DATA_W = 8;
	localparam int CFG_INDEX_W = 1;

	localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_DELAY = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_RATE = 1'd1;

	localparam logic [TIMER_W-1:0] REPEAT_DELAY_RST = 8'd15;
	localparam logic [TIMER_W-1:0] REPEAT_RATE_RST = 8'd4;

	typedef struct packed {
		logic [TIMER_W-1:0] delay;
		logic [TIMER_W-1:0] rate;
	} timer_cfg_t;

	typedef struct packed {
		logic accept;
		logic raw;
		logic prev;
	} lane_ctl_t;

	typedef struct packed {
		logic [LINE_W-1:0] held;
		logic [LINE_W-1:0] pressed;
		logic [LINE_W-1:0] released;
		logic [LINE_W-1:0] repeats;
	} result_t;

endpackage

>>> design/button_edge_autorepeat.sv
// top level: button edge detector with per-button auto-repeat
//
// usage
// - in channel: in_valid / in_ready carry one frame sample raw_buttons per item,
//   bit set means pressed
// - out channel: out_valid / out_ready carry one result item per input item:
//   held_mask, pressed_mask, released_mask, repeat_mask
// - config: cfg_we with cfg_index selects repeat_delay (0) or repeat_rate (1),
//   written from cfg_data; other indexes are dropped; write only while idle
// - latency: a result is valid the cycle after its sample is accepted
// - throughput: one item per cycle while out_ready is high; every button has its own timer lane and
//   all lanes step in the same cycle, the output register is the only stage
// - stall: while out_ready is low the result stays in the output register and
//   in_ready drops; in_ready rises again in the cycle the result is taken
// - reset: timers and previous sample clear to zero, repeat_delay = 15,
//   repeat_rate = 4, output register empty
// - lines at or above BUTTON_COUNT are masked off and read as zero
module button_edge_autorepeat #(
	parameter int BUTTON_COUNT = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [bea_pkg::LINE_W-1:0]         raw_buttons,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [bea_pkg::LINE_W-1:0]         held_mask,
	output logic [bea_pkg::LINE_W-1:0]         pressed_mask,
	output logic [bea_pkg::LINE_W-1:0]         released_mask,
	output logic [bea_pkg::LINE_W-1:0]         repeat_mask,
	input  logic                               cfg_we,
	input  logic [bea_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [bea_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import bea_pkg::*;

	// only the lines the fields carry exist
	localparam int LANES = (BUTTON_COUNT < LINE_W) ? BUTTON_COUNT : LINE_W;

	timer_cfg_t        cfg_q;
	logic [LINE_W-1:0] prev_q;
	logic [LINE_W-1:0] active;
	logic [LINE_W-1:0] raw;
	logic [LINE_W-1:0] fire;
	logic              accept;
	result_t           merged;
	result_t           result;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delay <= REPEAT_DELAY_RST;
			cfg_q.rate <= REPEAT_RATE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_REPEAT_DELAY: cfg_q.delay <= cfg_data[TIMER_W-1:0];
				REG_REPEAT_RATE: cfg_q.rate <= cfg_data[TIMER_W-1:0];
				default: ;
			endcase
		end
	end

	// mask of lines that have a button
	always_comb begin
		for (int i = 0; i < LINE_W; i++) begin
			active[i] = (i < LANES);
		end
	end

	assign raw = raw_buttons & active;
	assign accept = in_valid && in_ready;

	// previous frame sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (accept) begin
			prev_q <= raw;
		end
	end

	// one timer lane per button
	for (genvar g = 0; g < LINE_W; g++) begin : g_lane
		if (g < LANES) begin : g_on
			lane_ctl_t ctl;

			assign ctl.accept = accept;
			assign ctl.raw = raw[g];
			assign ctl.prev = prev_q[g];

			bea_lane u_lane (
				.clk    (clk),
				.arst_n (arst_n),
				.cfg    (cfg_q),
				.ctl    (ctl),
				.fire   (fire[g])
			);
		end else begin : g_off
			assign fire[g] = 1'b0;
		end
	end

	// merge lane results with the edge masks
	always_comb begin
		merged.held = raw;
		merged.pressed = raw & ~prev_q;
		merged.released = ~raw & prev_q;
		merged.repeats = fire;
	end

	bea_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept),
		.data_in   (merged),
		.can_load  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.data_out  (result)
	);

	assign held_mask = result.held;
	assign pressed_mask = result.pressed;
	assign released_mask = result.released;
	assign repeat_mask = result.repeats;

endmodule

>>> design/bea_lane.sv
// one button lane: repeat countdown timer and repeat pulse
module bea_lane (
	input  logic                clk,
	input  logic                arst_n,
	input  bea_pkg::timer_cfg_t cfg,
	input  bea_pkg::lane_ctl_t  ctl,
	output logic                fire
);
	import bea_pkg::*;

	logic [TIMER_W-1:0] count_q;
	logic [TIMER_W-1:0] count_d;

	always_comb begin
		fire = 1'b0;
		if (!ctl.raw) begin
			count_d = '0;
		end else if (!ctl.prev) begin
			count_d = cfg.delay;
		end else if (count_q != '0) begin
			count_d = count_q - TIMER_W'(1);
		end else begin
			fire = 1'b1;
			count_d = cfg.rate;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.accept) begin
			count_q <= count_d;
		end
	end

endmodule

>>> design/bea_out_buf.sv
// output register holding one result item until the receiver takes it
module bea_out_buf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  bea_pkg::result_t data_in,
	output logic             can_load,
	output logic             out_valid,
	input  logic             out_ready,
	output bea_pkg::result_t data_out
);
	import bea_pkg::*;

	logic    valid_q;
	result_t data_q;

	// free when empty or the held item leaves this cycle
	assign can_load = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign data_out = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= data_in;
		end
	end

endmodule
